/* src/first_fit_interval_booking_unit_macros.svh */
// Assertion macros for the first-fit interval booking unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef FIRST_FIT_INTERVAL_BOOKING_UNIT_MACROS_SVH
`define FIRST_FIT_INTERVAL_BOOKING_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FFIB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FFIB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ffib_pkg.sv */
// Shared types and constants of the first-fit interval booking unit.
// No dependencies.
`default_nettype none

package ffib_pkg;

   localparam int START_W = 30;
   localparam int DUR_W   = 24;
   localparam int TIME_W  = 33;
   // Candidate times carry two extra bits so that end + 1 + span never wraps.
   localparam int CAND_W  = 35;

   // Candidate interval travelling down the cell chain.
   typedef struct packed {
      logic              valid;
      logic              is_pref;
      logic              conflict;
      logic [CAND_W-1:0] first;
      logic [CAND_W-1:0] last;
   } token_type;

   // Entry of the candidate-start shift chain.
   typedef struct packed {
      logic              valid;
      logic [CAND_W-1:0] start;
   } cand_type;

   // Booking write, broadcast to all cells.
   typedef struct packed {
      logic [TIME_W-1:0] first;
      logic [TIME_W-1:0] last;
   } booking_type;

   // Chain control from the sequencer to every cell.
   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctl_type;

endpackage

`default_nettype wire

/* src/ffib_if.sv */
// Valid/ready channel interfaces for booking requests and responses.
// Depends on ffib_pkg for field widths.
`default_nettype none

interface ffib_req_if import ffib_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [START_W-1:0] preferred_start;
   logic [DUR_W-1:0]   duration;

   modport source(output valid, output preferred_start, output duration, input ready);
   modport sink(input valid, input preferred_start, input duration, output ready);
endinterface

interface ffib_rsp_if import ffib_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] booked_start;
   logic [TIME_W-1:0] booked_end;
   logic              rejected;

   modport source(output valid, output booked_start, output booked_end, output rejected,
                  input ready);
   modport sink(input valid, input booked_start, input booked_end, input rejected,
                output ready);
endinterface

`default_nettype wire

/* src/ffib_cell.sv */
// One booking cell: holds one stored booking, checks passing candidates
// against it and shifts candidate starts toward the head. Uses ffib_pkg.
`default_nettype none

module ffib_cell
   import ffib_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          occupied,
   input  wire logic          wr_en,
   input  wire booking_type   wr_data,
   input  wire chain_ctl_type ctl,
   input  wire token_type     tok_in,
   output      token_type     tok_out,
   input  wire cand_type      cand_in,
   output      cand_type      cand_out
);

   booking_type bk_ff;
   token_type   pass_ff, pass_in;
   cand_type    cstart_ff, cstart_in;
   logic        overlap;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bk_ff <= wr_data;
      end
   end

   // Overlap unless the booking ends before the candidate or starts after it.
   always_comb begin
      overlap = !(({2'b00, bk_ff.last} < tok_in.first) ||
                  ({2'b00, bk_ff.first} > tok_in.last));
      pass_in = tok_in;
      if (tok_in.valid && occupied && overlap) begin
         pass_in.conflict = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff.valid <= 1'b0;
      end else begin
         pass_ff.valid <= pass_in.valid;
      end
      pass_ff.is_pref  <= pass_in.is_pref;
      pass_ff.conflict <= pass_in.conflict;
      pass_ff.first    <= pass_in.first;
      pass_ff.last     <= pass_in.last;
   end

   always_comb begin
      cstart_in = cstart_ff;
      if (ctl.load) begin
         cstart_in.valid = occupied;
         cstart_in.start = {2'b00, bk_ff.last} + CAND_W'(1);
      end else if (ctl.shift) begin
         cstart_in = cand_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cstart_ff.valid <= 1'b0;
      end else begin
         cstart_ff.valid <= cstart_in.valid;
      end
      cstart_ff.start <= cstart_in.start;
   end

   assign tok_out  = pass_ff;
   assign cand_out = cstart_ff;

endmodule

`default_nettype wire

/* src/ffib_collect.sv */
// Result collector at the tail of the cell chain: records whether the
// preferred interval was free and the smallest free fallback start. Uses ffib_pkg.
`default_nettype none

module ffib_collect
   import ffib_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire token_type         tok,
   output      logic              pref_free,
   output      logic              found,
   output      logic [CAND_W-1:0] best
);

   logic              pref_free_ff, found_ff;
   logic [CAND_W-1:0] best_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pref_free_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (tok.valid && !tok.conflict) begin
         if (tok.is_pref) begin
            pref_free_ff <= 1'b1;
         end else if (!found_ff || tok.first < best_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tok.valid && !tok.conflict && !tok.is_pref && (!found_ff || tok.first < best_ff))
      begin
         best_ff <= tok.first;
      end
   end

   assign pref_free = pref_free_ff;
   assign found     = found_ff;
   assign best      = best_ff;

endmodule

`default_nettype wire

/* src/first_fit_interval_booking_unit.sv */
// Top level of the first-fit interval booking unit: sequencer, cell chain
// and response register. Uses ffib_pkg, ffib_if, ffib_cell, ffib_collect.
//
//   channel | dir | fields
//   req     | in  | preferred_start[29:0], duration[23:0]
//   rsp     | out | booked_start[32:0], booked_end[32:0], rejected
//
// From acceptance to the response register, MAX_BOOKINGS+2 candidate
// starts enter the cell chain one per cycle, and the last one passes
// every cell before the result is taken.
// A request against a full table skips the cell chain and goes straight to the done state.
// Reset empties the table at once; stored bookings are not cleared.
// A waiting response does not block acceptance of the next item.
`default_nettype none

module first_fit_interval_booking_unit
   import ffib_pkg::*;
#(
   parameter int MAX_BOOKINGS = 256
) (
   input wire logic  clock,
   input wire logic  reset,
   ffib_req_if.sink  req,
   ffib_rsp_if.source rsp
);

`include "first_fit_interval_booking_unit_macros.svh"

   localparam int CNT_W  = $clog2(MAX_BOOKINGS + 1);
   localparam int STEP_W = $clog2(2 * MAX_BOOKINGS + 2);
   localparam logic [STEP_W-1:0] LAST_INJ  = STEP_W'(MAX_BOOKINGS + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * MAX_BOOKINGS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               reject_ff, reject_in;
   logic [CAND_W-1:0]  pref_ff;
   logic [DUR_W-1:0]   span_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]  rsp_start_ff, rsp_end_ff;
   logic               rsp_rej_ff;

   logic               accept, slot_free, commit;
   logic [CAND_W-1:0]  grant_start, grant_end;
   chain_ctl_type      ctl;
   token_type          inj_tok;
   booking_type        wr_data;

   token_type          tok   [MAX_BOOKINGS+1];
   cand_type           cand  [MAX_BOOKINGS+1];

   logic               pref_free, found;
   logic [CAND_W-1:0]  best;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign commit    = (state_ff == ST_DONE) && slot_free && !reject_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      reject_in    = reject_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in   = '0;
               reject_in = (count_ff == CNT_W'(MAX_BOOKINGS));
               state_in  = reject_in ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (!reject_ff) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         reject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         reject_ff    <= reject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A zero duration books one unit, so the span stays at zero.
   always_ff @(posedge clock) begin
      if (accept) begin
         pref_ff <= CAND_W'(req.preferred_start);
         span_ff <= (req.duration == '0) ? '0 : req.duration - DUR_W'(1);
      end
   end

   // Step 0 injects the preferred start, step 1 time unit 1, then the
   // shifted-out starts one past each booking.
   always_comb begin
      ctl.load  = accept;
      ctl.shift = (state_ff == ST_RUN) && (step_ff >= STEP_W'(2));
      inj_tok.is_pref  = (step_ff == '0);
      inj_tok.conflict = 1'b0;
      if (step_ff == '0) begin
         inj_tok.first = pref_ff;
         inj_tok.valid = (state_ff == ST_RUN);
      end else if (step_ff == STEP_W'(1)) begin
         inj_tok.first = CAND_W'(1);
         inj_tok.valid = (state_ff == ST_RUN);
      end else begin
         inj_tok.first = cand[0].start;
         inj_tok.valid = (state_ff == ST_RUN) && (step_ff <= LAST_INJ) && cand[0].valid;
      end
      inj_tok.last = inj_tok.first + CAND_W'(span_ff);
   end

   assign tok[0]                = inj_tok;
   assign cand[MAX_BOOKINGS]    = '0;

   assign grant_start   = pref_free ? pref_ff : best;
   assign grant_end     = grant_start + CAND_W'(span_ff);
   assign wr_data.first = grant_start[TIME_W-1:0];
   assign wr_data.last  = grant_end[TIME_W-1:0];

   for (genvar i = 0; i < MAX_BOOKINGS; i++) begin : g_cell
      ffib_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .occupied (count_ff > CNT_W'(i)),
         .wr_en    (commit && (count_ff == CNT_W'(i))),
         .wr_data  (wr_data),
         .ctl      (ctl),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1]),
         .cand_in  (cand[i+1]),
         .cand_out (cand[i])
      );
   end

   ffib_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .clear     (accept),
      .tok       (tok[MAX_BOOKINGS]),
      .pref_free (pref_free),
      .found     (found),
      .best      (best)
   );

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && slot_free) begin
         rsp_rej_ff   <= reject_ff;
         rsp_start_ff <= reject_ff ? '0 : wr_data.first;
         rsp_end_ff   <= reject_ff ? '0 : wr_data.last;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.booked_start = rsp_start_ff;
   assign rsp.booked_end   = rsp_end_ff;
   assign rsp.rejected     = rsp_rej_ff;

   `FFIB_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_BOOKINGS),
      "booking count exceeds table size")
   `FFIB_ASSERT_NEXT(a_commit_count, commit, count_ff == $past(count_ff) + CNT_W'(1),
      "committed booking did not advance the count")
   `FFIB_ASSERT_NOW(a_reject_zero, rsp_valid_ff && rsp_rej_ff,
      rsp_start_ff == '0 && rsp_end_ff == '0, "rejected item carries a nonzero interval")
   `FFIB_ASSERT_NOW(a_grant_found, commit, pref_free || found,
      "no free start found for a granted item")

endmodule

`default_nettype wire
